// ===== hdl/khbe_pkg.sv =====
// shared types, constants and hash helper functions for the keyed hash byte encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package khbe_pkg;

  localparam int unsigned HashWidth = 28;
  localparam int unsigned SumWidth  = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CodeWidth = 16;
  localparam int unsigned NibCount  = SumWidth / 4;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiA    = 8'h61;

  // item held between the input register and the hash logic
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic [SumWidth-1:0]  sum;
  } khbe_stage_t;

  // lowercase ascii hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = AsciiZero + {4'd0, nib};
    end else begin
      c = AsciiA + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

  // one elf hash step, top nibble folded back into bits 7:4 and cleared
  function automatic logic [HashWidth-1:0] elf_step(input logic [HashWidth-1:0] h,
                                                    input logic [7:0] c);
    logic [31:0] s;
    s = {h, 4'd0} + {24'd0, c};
    return {s[27:8], s[7:4] ^ s[31:28], s[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/khbe_front.sv =====
// input register and running sum of the keyed hash byte encoder
// depends on khbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module khbe_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [khbe_pkg::ByteWidth-1:0] data_byte,
  input  wire logic                          start_of_stream,
  input  wire logic                          drain,
  output logic                               stage_valid,
  output khbe_pkg::khbe_stage_t              stage
);
  import khbe_pkg::*;

  logic [SumWidth-1:0] running_sum;
  logic [SumWidth-1:0] sum_used;
  logic                accept;

  assign in_ready = !stage_valid || drain;
  assign accept   = in_valid && in_ready;
  // start flag clears the sum before this byte
  assign sum_used = start_of_stream ? '0 : running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      running_sum <= '0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (accept) begin
        running_sum <= sum_used + {{(SumWidth-ByteWidth){1'b0}}, data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.data <= data_byte;
      stage.sum  <= sum_used;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && start_of_stream) |=> (stage.sum == '0))
    else $error("start of stream did not clear the hashed sum");

  a_sum_adds: assert property (@(posedge clk) disable iff (rst)
    accept |=> (running_sum == stage.sum + {{(SumWidth-ByteWidth){1'b0}}, stage.data}))
    else $error("running sum not advanced by the accepted byte");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("input register empty but input not ready");

endmodule

`default_nettype wire

// ===== hdl/khbe_hash.sv =====
// elf hash over the hex text of the running sum, fold and byte add
// depends on khbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module khbe_hash (
  input  wire logic [khbe_pkg::HashWidth-1:0] prefix,
  input  wire khbe_pkg::khbe_stage_t          stage,
  output logic [khbe_pkg::CodeWidth-1:0]      code
);
  import khbe_pkg::*;

  logic [HashWidth-1:0] h;
  logic [16:0]          fold_sum;

  always_comb begin
    h = prefix;
    // most significant nibble first
    for (int i = NibCount - 1; i >= 0; i--) begin
      h = elf_step(h, hex_char(stage.sum[4*i +: 4]));
    end
    fold_sum = {5'd0, h[HashWidth-1:16]} + {1'b0, h[15:0]};
    code     = fold_sum[16:1] + {{(CodeWidth-ByteWidth){1'b0}}, stage.data};
  end

endmodule

`default_nettype wire

// ===== hdl/keyed_hash_byte_encoder.sv =====
// Keyed hash byte encoder: one 16-bit code word for each input byte. The block
// keeps a wrapping 32-bit sum of the bytes since the stream started (an item
// with start_of_stream set clears it first) and continues an elf hash from the
// key prefix register over the eight lowercase hex characters of that sum, most
// significant first. The 28-bit hash h is folded to ((h >> 16) + h[15:0]) >> 1,
// the byte is added and the low 16 bits form code_word. Throughput is one item
// per clock while the receiver keeps out_ready high; an accepted item passes
// from the input register through the eight hash steps into the result
// register on code_word, and is held while out_ready is low. The running sum
// is updated at acceptance, so back-to-back items see each other's bytes.
// key_prefix_hash is written through cfg_wr_en and cfg_wr_data and should only
// change while no item is in flight.
// depends on khbe_pkg, khbe_front, khbe_hash
`timescale 1ns / 1ps
`default_nettype none

module keyed_hash_byte_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [khbe_pkg::HashWidth-1:0] cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [khbe_pkg::ByteWidth-1:0] data_byte,
  input  wire logic                           start_of_stream,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [khbe_pkg::CodeWidth-1:0]      code_word
);
  import khbe_pkg::*;

  logic [HashWidth-1:0] key_prefix_hash;
  logic                 drain;
  logic                 stage_valid;
  khbe_stage_t          stage;
  logic [CodeWidth-1:0] code;

  // result register empties or is being taken this cycle
  assign drain = !out_valid || out_ready;

  // key prefix register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_prefix_hash <= '0;
    end else if (cfg_wr_en) begin
      key_prefix_hash <= cfg_wr_data;
    end
  end

  // input register and running sum
  khbe_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .start_of_stream (start_of_stream),
    .drain           (drain),
    .stage_valid     (stage_valid),
    .stage           (stage)
  );

  // combinational hash, fold and add
  khbe_hash u_hash (
    .prefix (key_prefix_hash),
    .stage  (stage),
    .code   (code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && stage_valid) begin
      code_word <= code;
    end
  end

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both registers are full and stalled");

  a_item_moves_on: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && drain) |=> out_valid)
    else $error("held item not passed to the result register");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stage_valid)
    else $error("accepted item lost before the hash stage");

endmodule

`default_nettype wire

// ===== tb/sv/keyed_hash_byte_encoder_tb.sv =====
// self-checking testbench for keyed_hash_byte_encoder: streams bytes through the block
// and predicts each code word from an elf hash of the running sum; depends on khbe_pkg
`timescale 1ns / 1ps

module keyed_hash_byte_encoder_tb;
  import khbe_pkg::*;

  localparam int StallLimit = 4000;  // cycles with no item moved on either side
  localparam int HoldCycles = 300;   // long receiver hold-off that backs up the input
  localparam int PhaseItems = 390;   // random items per key prefix setting
  localparam int PhaseCount = 5;

  typedef enum {RxSteady, RxPattern, RxCoin, RxSparse} rx_mode_t;

  // predicted code words in order of acceptance, plus the running sum and key prefix
  class code_word_scoreboard;
    logic [HashWidth-1:0] key_prefix;
    logic [SumWidth-1:0]  stream_sum;
    logic [CodeWidth-1:0] expected_codes[$];
    int                   errors;

    function new();
      key_prefix = '0;
      stream_sum = '0;
      errors     = 0;
    endfunction

    // elf hash continued from the key prefix over the lowercase hex text of the sum
    function logic [CodeWidth-1:0] predict_code_word(logic [ByteWidth-1:0] b);
      logic [31:0] h;
      logic [31:0] top;
      logic [31:0] folded;
      logic [3:0]  nib;
      logic [7:0]  ch;
      h = {4'd0, key_prefix};
      for (int i = NibCount - 1; i >= 0; i--) begin
        nib = stream_sum[4*i +: 4];
        ch  = (nib < 4'd10) ? AsciiZero + nib : AsciiA + (nib - 4'd10);
        h   = (h << 4) + ch;
        top = h & 32'hF000_0000;
        h   = (h ^ (top >> 24)) & ~top;
      end
      folded = ((h >> 16) + (h & 32'h0000_FFFF)) >> 1;
      return CodeWidth'(folded + b);
    endfunction

    function void note_byte(logic [ByteWidth-1:0] b, logic sos);
      if (sos) begin
        stream_sum = '0;
      end
      expected_codes.push_back(predict_code_word(b));
      stream_sum = stream_sum + b;
    endfunction

    function void check_code_word(logic [CodeWidth-1:0] actual);
      logic [CodeWidth-1:0] wanted;
      if (expected_codes.size() == 0) begin
        errors++;
        $error("code_word: expected nothing, actual %h", actual);
      end else begin
        wanted = expected_codes.pop_front();
        if (actual !== wanted) begin
          errors++;
          $error("code_word: expected %h, actual %h", wanted, actual);
        end
      end
    endfunction

    function int outstanding();
      return expected_codes.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [HashWidth-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ByteWidth-1:0] data_byte = '0;
  logic                 start_of_stream = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CodeWidth-1:0] code_word;

  logic                 want_hold = 1'b0;  // asks the receiver for its long hold-off
  int                   idle_cycles = 0;

  code_word_scoreboard  sb;

  keyed_hash_byte_encoder dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .start_of_stream (start_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .code_word       (code_word)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one item and hold it until the block takes it
  task automatic offer_byte(input logic [ByteWidth-1:0] b, input logic sos);
    in_valid        <= 1'b1;
    data_byte       <= b;
    start_of_stream <= sos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_key_prefix(input logic [HashWidth-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    sb.key_prefix  = value;
  endtask

  // stop offering and wait until every predicted code word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // streams of random length, biased towards 0x00 and 0xff bytes; the sender
  // works in bursts unless steady is set
  task automatic run_random_phase(input int count, input bit steady);
    int                   burst_left;
    int                   stream_left;
    int                   pick;
    logic [ByteWidth-1:0] b;
    logic                 sos;
    burst_left  = $urandom_range(1, 24);
    // a small carry-over lets some streams run on across a new key prefix
    stream_left = $urandom_range(0, 20);
    for (int n = 0; n < count; n++) begin
      sos = 1'b0;
      if (stream_left == 0) begin
        sos         = 1'b1;
        stream_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(1, 60);
      end else if ($urandom_range(0, 199) == 0) begin
        sos = 1'b1;  // stray restart in the middle of a stream
      end
      stream_left--;
      pick = $urandom_range(0, 15);
      b    = (pick == 0) ? 8'h00 : (pick < 3) ? 8'hFF : ByteWidth'($urandom);
      offer_byte(b, sos);
      if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          idle_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  // receiver: ready follows a mode picked afresh every so often, plus one long hold-off
  initial begin
    rx_mode_t       mode;
    int             chunk_left;
    int             tick;
    logic [7:0]     stall_mask;
    bit             hold_done;
    logic           ready_now;
    mode       = RxSteady;
    chunk_left = 0;
    tick       = 0;
    stall_mask = '1;
    hold_done  = 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (chunk_left == 0) begin
          mode       = rx_mode_t'($urandom_range(0, 3));
          chunk_left = $urandom_range(16, 128);
          stall_mask = 8'($urandom);
        end
        chunk_left--;
        tick++;
        case (mode)
          RxSteady:  ready_now = 1'b1;
          RxPattern: ready_now = stall_mask[tick[2:0]];
          RxCoin:    ready_now = 1'($urandom_range(0, 1));
          default:   ready_now = ($urandom_range(0, 3) == 0);
        endcase
        out_ready <= ready_now;
        @(posedge clk);
      end
    end
  end

  // both channels sampled at the edge, before any of this edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_byte(data_byte, start_of_stream);
      end
      if (out_valid && out_ready) begin
        sb.check_code_word(code_word);
      end
    end
  end

  // watchdog on cycles where no item moves at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [HashWidth-1:0] key_prefixes [PhaseCount];
    // directed items: field extremes, restarts, and runs of 0xff so that the
    // hex text of the sum takes letters as well as digits
    logic [ByteWidth-1:0] dir_bytes [$] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01,
                                           8'hFE, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                                           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                                           8'h00, 8'hFF};
    logic                 dir_sos [$]   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                           1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                           1'b1, 1'b0};
    sb = new();
    key_prefixes[0] = 28'h0FF_FFFF | 28'hF00_0000;  // every bit set
    key_prefixes[1] = HashWidth'($urandom);
    key_prefixes[2] = '0;                           // empty key
    key_prefixes[3] = HashWidth'($urandom);
    key_prefixes[4] = HashWidth'($urandom);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part runs on the reset prefix of zero, the empty key case
    foreach (dir_bytes[i]) begin
      offer_byte(dir_bytes[i], dir_sos[i]);
    end
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      write_key_prefix(key_prefixes[p]);
      if (p == 2) begin
        // long receiver hold-off with the sender going flat out
        want_hold <= 1'b1;
        run_random_phase(PhaseItems, 1'b1);
      end else begin
        run_random_phase(PhaseItems, $urandom_range(0, 3) == 0);
      end
      wait_drained();
    end

    // results pass through the input and result registers; leave room for anything stray
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.errors++;
      $error("code_word: %0d expected items never arrived", sb.outstanding());
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
